// ===== rtl/mandelbrot_escape_time_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the escape-time pixel block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mep assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mep assertion failed");

`endif

// ===== rtl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Types and constants shared by the escape-time pixel modules.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int ITER_LIMIT_DEF = 1000;

  localparam int C_W     = 32;
  localparam int Z_W     = 33;
  localparam int OP_W    = 30;
  localparam int PROD_W  = 2 * OP_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC    = 28;
  localparam int CNT_OUT_W = 10;
  localparam int CHAN_W  = 8;

  localparam logic signed [Z_W-1:0] TWO_Q28     = 33'sd536870912;
  localparam logic signed [Z_W-1:0] NEG_TWO_Q28 = -33'sd536870912;
  localparam logic signed [SUM_W-1:0] FOUR_Q56  = 61'sh0400_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_XY,
    ST_UPD,
    ST_FIN,
    ST_LOAD
  } state_t;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_en;
    logic     upd;
  } ctrl_t;

  typedef struct packed {
    logic big;
    logic esc;
  } stat_t;

endpackage

// ===== rtl/mep_datapath.sv =====
// ----------------------------------------------------------------------------
// mep_datapath
// Holds c and z and runs the single shared multiplier that forms x*x, y*y
// and x*y in turn, then updates z.
// ----------------------------------------------------------------------------
module mep_datapath
  import mep_pkg::*;
(
  input  logic                    clk,
  input  logic signed [C_W-1:0]   c_real,
  input  logic signed [C_W-1:0]   c_imag,
  input  ctrl_t                   ctrl,
  output stat_t                   stat
);

  logic signed [C_W-1:0]    cr_r, ci_r;
  logic signed [Z_W-1:0]    x_r, y_r;
  logic signed [PROD_W-1:0] x2_r, y2_r, xy_r, diff_r;
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_XX: begin
        op_a = $signed(x_r[OP_W-1:0]);
        op_b = $signed(x_r[OP_W-1:0]);
      end
      MUL_YY: begin
        op_a = $signed(y_r[OP_W-1:0]);
        op_b = $signed(y_r[OP_W-1:0]);
      end
      default: begin
        op_a = $signed(x_r[OP_W-1:0]);
        op_b = $signed(y_r[OP_W-1:0]);
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign sum  = SUM_W'(x2_r) + SUM_W'(y2_r);

  assign stat.big = (x_r >= TWO_Q28) || (x_r <= NEG_TWO_Q28) ||
                    (y_r >= TWO_Q28) || (y_r <= NEG_TWO_Q28);
  assign stat.esc = (sum >= FOUR_Q56);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cr_r <= c_real;
      ci_r <= c_imag;
      x_r  <= '0;
      y_r  <= '0;
    end else if (ctrl.upd) begin
      x_r <= Z_W'(diff_r >>> FRAC) + Z_W'(cr_r);
      y_r <= Z_W'(xy_r >>> (FRAC - 1)) + Z_W'(ci_r);
    end
    if (ctrl.mul_en) begin
      case (ctrl.mul_sel)
        MUL_XX:  x2_r <= prod;
        MUL_YY:  y2_r <= prod;
        default: xy_r <= prod;
      endcase
    end
    if (ctrl.diff_en) begin
      diff_r <= x2_r - y2_r;
    end
  end

endmodule

// ===== rtl/mep_seq.sv =====
// ----------------------------------------------------------------------------
// mep_seq
// Sequencer for one point: steps the shared multiplier through the three
// products of each iteration, counts iterations and hands off the result.
// ----------------------------------------------------------------------------
module mep_seq
  import mep_pkg::*;
#(
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
)
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            out_free,
  input  stat_t                           stat,
  output ctrl_t                           ctrl,
  output logic                            rom_rd,
  output logic [$clog2(ITER_LIMIT)-1:0]   rom_addr,
  output logic                            out_load,
  output logic [$clog2(ITER_LIMIT+1)-1:0] count
);

  localparam int CW = $clog2(ITER_LIMIT + 1);
  localparam int AW = $clog2(ITER_LIMIT);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          at_limit;

  assign at_limit = (count_r == CW'(ITER_LIMIT));
  assign count    = count_r;
  assign rom_addr = at_limit ? '0 : count_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQX;
      end
      ST_SQX: begin
        if (at_limit || stat.big) state_nxt = ST_FIN;
        else                      state_nxt = ST_SQY;
      end
      ST_SQY:  state_nxt = ST_XY;
      ST_XY: begin
        if (stat.esc) state_nxt = ST_FIN;
        else          state_nxt = ST_UPD;
      end
      ST_UPD:  state_nxt = ST_SQX;
      ST_FIN:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.mul_sel = MUL_XX;
    in_ready  = 1'b0;
    rom_rd    = 1'b0;
    out_load  = 1'b0;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          count_nxt = '0;
        end
      end
      ST_SQX: begin
        ctrl.mul_en  = !(at_limit || stat.big);
        ctrl.mul_sel = MUL_XX;
      end
      ST_SQY: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_YY;
      end
      ST_XY: begin
        ctrl.mul_en  = !stat.esc;
        ctrl.mul_sel = MUL_XY;
        ctrl.diff_en = !stat.esc;
      end
      ST_UPD: begin
        ctrl.upd  = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      ST_FIN:  rom_rd = 1'b1;
      ST_LOAD: out_load = out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mep_palette_rom.sv =====
// ----------------------------------------------------------------------------
// mep_palette_rom
// Palette built at elaboration from a fixed-point cosine, one RGB entry per
// iteration count, read with a registered output.
// ----------------------------------------------------------------------------
module mep_palette_rom
  import mep_pkg::*;
#(
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
)
(
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(ITER_LIMIT)-1:0] addr,
  output logic [3*CHAN_W-1:0]           rgb
);

  localparam longint          ONE30     = 64'sd1073741824;
  localparam longint unsigned PI40      = 64'h3243F6A8886;
  localparam longint unsigned TWO_PI40  = 64'h6487ED5110B;
  localparam longint unsigned HALF_PI40 = 64'h1921FB54443;
  localparam longint unsigned THREE40   = 64'h300_0000_0000;
  localparam longint unsigned ITER_LIMIT_U = longint'(ITER_LIMIT);
  localparam longint TAYLOR_DIV [1:9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

  typedef logic [3*CHAN_W-1:0] pal_t [ITER_LIMIT];

  function automatic logic [CHAN_W-1:0] chan(input longint unsigned n,
                                             input longint unsigned k);
    longint unsigned a;
    longint unsigned t;
    longint unsigned v;
    longint          t2;
    longint          r;
    logic            neg;
    neg = 1'b0;
    a = THREE40 + (PI40 * k * n) / ITER_LIMIT_U;
    a = a % TWO_PI40;
    if (a > PI40) a = TWO_PI40 - a;
    if (a > HALF_PI40) begin
      a   = PI40 - a;
      neg = 1'b1;
    end
    t  = (a + 64'd512) >> 10;
    t2 = longint'((t * t) >> 30);
    r  = ONE30;
    for (int i = 9; i >= 1; i--) begin
      r = ONE30 - ((r * t2) >>> 30) / TAYLOR_DIV[i];
    end
    if (r > ONE30)  r = ONE30;
    if (r < -ONE30) r = -ONE30;
    if (neg) r = -r;
    v = 64'd255 * longint'(ONE30 + r);
    return CHAN_W'((v + 64'd1073741824) >> 31);
  endfunction

  function automatic pal_t build_pal();
    pal_t p;
    for (int n = 0; n < ITER_LIMIT; n++) begin
      p[n] = {chan(longint'(n), 64'd1), chan(longint'(n), 64'd2),
              chan(longint'(n), 64'd4)};
    end
    return p;
  endfunction

  localparam pal_t PAL = build_pal();

  logic [3*CHAN_W-1:0] rgb_r;

  always_ff @(posedge clk) begin
    if (rd_en) rgb_r <= PAL[addr];
  end

  assign rgb = rgb_r;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time iteration for one point c given as signed Q4.28 real and
// imaginary parts. One 30x30 multiplier is shared for x*x, y*y and x*y, so
// each iteration of z = z*z + c steps through the states SQX, SQY, XY and
// UPD, and a point inside the set runs all ITER_LIMIT iterations. The input
// is ready again in the cycle after the result is loaded into the output
// register; a waiting result holds the block in its final step until taken.
// Colors come from a palette ROM of ITER_LIMIT entries built at elaboration.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_assert.svh"

module mandelbrot_escape_time_pixel
  import mep_pkg::*;
#(
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [C_W-1:0]   in_c_real,
  input  logic signed [C_W-1:0]   in_c_imag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CNT_OUT_W-1:0]    out_iter_count,
  output logic                    out_inside_set,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue
);

  localparam int CW = $clog2(ITER_LIMIT + 1);
  localparam int AW = $clog2(ITER_LIMIT);

  ctrl_t                ctrl;
  stat_t                stat;
  logic                 rom_rd;
  logic [AW-1:0]        rom_addr;
  logic [3*CHAN_W-1:0]  rom_rgb;
  logic                 out_load;
  logic                 out_free;
  logic [CW-1:0]        count;
  logic [CW+CNT_OUT_W-1:0] count_ext;
  logic                 pt_in_set;

  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_OUT_W-1:0] iter_count_r;
  logic                 inside_set_r;
  logic [CHAN_W-1:0]    red_r, green_r, blue_r;

  mep_datapath u_datapath (
    .clk    (clk),
    .c_real (in_c_real),
    .c_imag (in_c_imag),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  mep_seq #(
    .ITER_LIMIT (ITER_LIMIT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .rom_rd   (rom_rd),
    .rom_addr (rom_addr),
    .out_load (out_load),
    .count    (count)
  );

  mep_palette_rom #(
    .ITER_LIMIT (ITER_LIMIT)
  ) u_palette (
    .clk   (clk),
    .rd_en (rom_rd),
    .addr  (rom_addr),
    .rgb   (rom_rgb)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign count_ext = {{CNT_OUT_W{1'b0}}, count};
  assign pt_in_set = (count == CW'(ITER_LIMIT));

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      iter_count_r <= count_ext[CNT_OUT_W-1:0];
      inside_set_r <= pt_in_set;
      red_r        <= pt_in_set ? '0 : rom_rgb[3*CHAN_W-1:2*CHAN_W];
      green_r      <= pt_in_set ? '0 : rom_rgb[2*CHAN_W-1:CHAN_W];
      blue_r       <= pt_in_set ? '0 : rom_rgb[CHAN_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = iter_count_r;
  assign out_inside_set = inside_set_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;

  `MEP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `MEP_ASSERT_NOW(a_inside_black, clk, rst_n, out_valid && out_inside_set, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
  `MEP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count <= CW'(ITER_LIMIT))
  `MEP_ASSERT_NOW(a_load_when_free, clk, rst_n, out_load, !out_valid_r || out_ready)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Escape-time pixel testbench
// Sends complex points to the escape-time pixel block and checks every pixel
// that comes back against a predictor run in the testbench. Directed points
// cover the range limits, the fast-escape paths and slow points near the set
// boundary. Random points mix full-range values with points close to the set.
// Both sides idle at random, and the sender pauses until the block drains.
// ----------------------------------------------------------------------------
module tb_top
  import mep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITER = ITER_LIMIT_DEF;
  localparam int N_RANDOM = 600;
  localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;

  localparam longint TWO_Z = 64'sd2 <<< FRAC;
  localparam longint FOUR_ZZ = 64'sd4 <<< (2 * FRAC);
  localparam longint ONE30 = 64'sh4000_0000;
  localparam longint unsigned PI40 = 64'h3243F6A8886;
  localparam longint unsigned TWO_PI40 = 64'h6487ED5110B;
  localparam longint unsigned HALF_PI40 = 64'h1921FB54443;
  localparam longint unsigned THREE40 = 64'd3 << 40;

  typedef struct {
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
    bit                    drain;
    int                    gap;
  } point_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic                 in_set;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [C_W-1:0] in_c_real = '0;
  logic signed [C_W-1:0] in_c_imag = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CNT_OUT_W-1:0]  out_iter_count;
  logic                  out_inside_set;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;

  point_t point_q[$];
  pixel_t pixel_q[$];

  int n_points = 0;
  int n_sent = 0;
  int n_done = 0;
  int n_errors = 0;
  int n_inside = 0;
  int n_escaped = 0;
  int deepest = 0;
  int wait_left = 0;
  int stall_left = 0;
  longint unsigned n_cycles = 0;
  point_t cur;
  pixel_t want;

  mandelbrot_escape_time_pixel #(
    .ITER_LIMIT(N_ITER)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_c_real(in_c_real),
    .in_c_imag(in_c_imag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_iter_count(out_iter_count),
    .out_inside_set(out_inside_set),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint cos_q30(longint unsigned t);
    longint t2;
    longint r;
    longint d;
    t2 = longint'((t * t) >> 30);
    r = ONE30;
    for (int i = 9; i >= 1; i--) begin
      d = 2 * i * (2 * i - 1);
      r = ONE30 - ((r * t2) >>> 30) / d;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] palette_channel(longint unsigned n,
                                                        longint unsigned k);
    longint unsigned a;
    longint unsigned v;
    longint c;
    bit neg;
    neg = 1'b0;
    a = THREE40 + (PI40 * k * n) / longint'(N_ITER);
    a = a % TWO_PI40;
    if (a > PI40) begin
      a = TWO_PI40 - a;
    end
    if (a > HALF_PI40) begin
      a = PI40 - a;
      neg = 1'b1;
    end
    c = cos_q30((a + 64'd512) >> 10);
    if (c > ONE30) begin
      c = ONE30;
    end
    if (c < -ONE30) begin
      c = -ONE30;
    end
    if (neg) begin
      c = -c;
    end
    v = longint'(ONE30 + c) * 64'd255;
    return CHAN_W'((v + (64'd1 << 30)) >> 31);
  endfunction

  function automatic pixel_t escape_pixel(logic signed [C_W-1:0] re,
                                          logic signed [C_W-1:0] im);
    longint x;
    longint y;
    longint x2;
    longint y2;
    longint xy;
    longint cr;
    longint ci;
    int n;
    pixel_t p;
    cr = re;
    ci = im;
    x = 0;
    y = 0;
    n = 0;
    while (n < N_ITER) begin
      if (x >= TWO_Z || x <= -TWO_Z || y >= TWO_Z || y <= -TWO_Z) begin
        break;
      end
      x2 = x * x;
      y2 = y * y;
      if (x2 + y2 >= FOUR_ZZ) begin
        break;
      end
      xy = x * y;
      x = ((x2 - y2) >>> FRAC) + cr;
      y = (xy >>> (FRAC - 1)) + ci;
      n++;
    end
    p.count = CNT_OUT_W'(n);
    if (n < N_ITER) begin
      p.in_set = 1'b0;
      p.red = palette_channel(n, 1);
      p.green = palette_channel(n, 2);
      p.blue = palette_channel(n, 4);
    end else begin
      p.in_set = 1'b1;
      p.red = '0;
      p.green = '0;
      p.blue = '0;
    end
    return p;
  endfunction

  task automatic add_point(logic signed [C_W-1:0] re, logic signed [C_W-1:0] im,
                           int gap);
    point_t p;
    p.re = re;
    p.im = im;
    p.drain = 1'b0;
    p.gap = gap;
    point_q.insert(point_q.size(), p);
    n_points++;
  endtask

  task automatic add_drain();
    point_t p;
    p.re = '0;
    p.im = '0;
    p.drain = 1'b1;
    p.gap = 0;
    point_q.insert(point_q.size(), p);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        pixel_q.insert(pixel_q.size(), escape_pixel(in_c_real, in_c_imag));
        n_sent++;
        if (point_q.size() != 0) begin
          wait_left = point_q[0].gap;
        end
      end
      if (!in_valid || in_ready) begin
        if (wait_left != 0) begin
          wait_left--;
          in_valid <= 1'b0;
        end else if (point_q.size() != 0 && point_q[0].drain) begin
          in_valid <= 1'b0;
          if (n_done == n_sent) begin
            void'(point_q.pop_front());
          end
        end else if (point_q.size() != 0) begin
          cur = point_q.pop_front();
          in_valid <= 1'b1;
          in_c_real <= cur.re;
          in_c_imag <= cur.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_done <= n_done + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t ns: unexpected pixel, expected none, actual count %0d",
                   $time, out_iter_count);
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("iter_count", want.count, out_iter_count);
          check_field("inside_set", want.in_set, out_inside_set);
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          if (want.in_set) begin
            n_inside++;
          end else begin
            n_escaped++;
            if (want.count > deepest) begin
              deepest = want.count;
            end
          end
        end
        stall_left = ((n_done / 64) % 3 == 2) ? 0 : $urandom_range(0, 3);
        out_ready <= (stall_left == 0);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d of %0d pixels received", $time, n_done, n_points);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
    int gap;

    add_point(32'h0000_0000, 32'h0000_0000, 0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_point(32'h8000_0000, 32'h8000_0000, 0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 2);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_point(32'h0000_0000, 32'h7FFF_FFFF, 3);
    add_point(32'h0000_0000, 32'h8000_0000, 0);
    add_point(32'h8000_0000, 32'h0000_0000, 1);
    add_point(32'h7FFF_FFFF, 32'h0000_0000, 0);
    add_point(32'hE000_0000, 32'h0000_0000, 0);
    add_point(32'h2000_0000, 32'h0000_0000, 2);
    add_point(32'h1000_0000, 32'h0000_0000, 0);
    add_point(32'h1800_0000, 32'h1800_0000, 0);
    add_point(32'h1000_0000, 32'h1000_0000, 3);
    add_point(32'h0400_0000, 32'h0000_0000, 0);
    add_point(32'hF400_0000, 32'h0000_0000, 1);
    add_point(32'h0000_0000, 32'h1000_0000, 0);
    add_point(32'hF000_0000, 32'h0000_0000, 0);
    add_point(32'h0400_1000, 32'h0000_0000, 2);
    add_point(32'hF400_0000, 32'h0010_0000, 0);
    add_point(32'hFFFF_FFFF, 32'h0000_0001, 0);
    add_drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        add_drain();
      end
      if ($urandom_range(0, 9) < 3) begin
        re = $urandom;
        im = $urandom;
      end else begin
        re = $urandom_range(0, 671088640) - 536870912;
        im = $urandom_range(0, 671088640) - 335544320;
      end
      gap = ((i / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
      add_point(re, im, gap);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == n_points);
    wait (n_done == n_points);
    repeat (40) @(posedge clk);

    if (pixel_q.size() != 0) begin
      $display("%0t ns: %0d expected pixels never arrived", $time, pixel_q.size());
      n_errors += pixel_q.size();
    end
    $display("Checked %0d points: %0d inside the set, %0d escaped.",
             n_done, n_inside, n_escaped);
    $display("Slowest escape took %0d iterations; %0d mismatches seen.", deepest, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mep_pkg.sv
rtl/mep_datapath.sv
rtl/mep_seq.sv
rtl/mep_palette_rom.sv
rtl/mandelbrot_escape_time_pixel.sv
tb/tb_top.sv
